@@ hdl/rqlr_pkg.sv @@
// Shared types, constants and codes for the requantise / leaky ReLU block.
// No dependencies; used by every module under hdl.
package rqlr_pkg;

   localparam int MAX_CHANNEL_COUNT = 512;  // power of two
   localparam int LANE_COUNT        = 16;

   localparam int DATA_W    = 32;
   localparam int SHIFT_W   = 6;
   localparam int OUT_W     = 8;
   localparam int TCH_W     = 9;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W     = CFG_W + 1;
   localparam int TAB_IDX_W = $clog2(MAX_CHANNEL_COUNT);
   localparam int LANE_W    = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
   localparam int STEP_W    = $clog2(SUM_W);
   localparam int DVS_W     = SUM_W + CFG_W;

   localparam int MQ_DEPTH  = 4;
   localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);
   localparam int OQ_DEPTH  = 8;
   localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W  = OQ_PTR_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_LIMIT   = 2'd2;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_TABLE = 1'b1;

   localparam logic [CFG_W-1:0] CHANNEL_COUNT_RESET = 10'd1;
   localparam logic [CFG_W-1:0] CHANNEL_LIMIT_RESET = 10'd512;

   localparam logic signed [DATA_W-1:0] SAT_HI = 32'sd127;
   localparam logic signed [DATA_W-1:0] SAT_LO = -32'sd128;
   localparam logic signed [11:0] LEAK_MUL = 12'sd13;
   localparam int LEAK_SHIFT = 7;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIVIDE,
      FE_PUSH
   } fe_state_type;

   // data: value = conv (+ residual); table write: value = bias
   typedef struct packed {
      logic                 kind;
      logic                 last;
      logic                 zero;
      logic [TAB_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    value;
      logic [DATA_W-1:0]    mult;
      logic [SHIFT_W-1:0]   shift;
   } mid_entry_type;

   typedef struct packed {
      logic [DATA_W-1:0]  bias;
      logic [DATA_W-1:0]  mult;
      logic [SHIFT_W-1:0] shift;
   } tab_entry_type;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             last;
   } out_entry_type;

endpackage

@@ hdl/rqlr_mid_queue.sv @@
// Short queue between the front and back ends of the requantise block.
// Depends on rqlr_pkg.
module rqlr_mid_queue
   import rqlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_en,
   input  mid_entry_type push_data,
   output logic          q_full,
   input  logic          pop_en,
   output mid_entry_type head,
   output logic          q_empty
);

   mid_entry_type         mem_ff [MQ_DEPTH];
   logic [MQ_PTR_W:0]     wr_ff, wr_in;
   logic [MQ_PTR_W:0]     rd_ff, rd_in;

   assign q_empty = (wr_ff == rd_ff);
   assign q_full  = (wr_ff[MQ_PTR_W-1:0] == rd_ff[MQ_PTR_W-1:0]) &&
                    (wr_ff[MQ_PTR_W] != rd_ff[MQ_PTR_W]);
   assign head    = mem_ff[rd_ff[MQ_PTR_W-1:0]];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push_en && !q_full) begin
         wr_in = wr_ff + 1'b1;
      end
      if (pop_en && !q_empty) begin
         rd_in = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && !q_full) begin
         mem_ff[wr_ff[MQ_PTR_W-1:0]] <= push_data;
      end
   end

endmodule

@@ hdl/rqlr_front.sv @@
// Front end: configuration registers, lane/channel tracking, residual add.
// Classifies each transaction and queues it for the back end. Depends on rqlr_pkg.
module rqlr_front
   import rqlr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid,
   output logic                 ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_kind,
   input  logic [DATA_W-1:0]    req_conv_value,
   input  logic [DATA_W-1:0]    req_residual_value,
   input  logic                 req_in_last,
   input  logic [TCH_W-1:0]     req_table_channel,
   input  logic [DATA_W-1:0]    req_table_bias,
   input  logic [DATA_W-1:0]    req_table_multiplier,
   input  logic [SHIFT_W-1:0]   req_table_shift,
   output logic                 mq_push,
   output mid_entry_type        mq_data,
   input  logic                 mq_full
);

   logic [CFG_W-1:0]  count_ff;
   logic              res_en_ff;
   logic [CFG_W-1:0]  limit_ff;
   logic [CFG_W-1:0]  vbase_ff, vbase_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   fe_state_type      state_ff, state_in;
   mid_entry_type     hold_ff, hold_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CFG_W-1:0]  count_eff;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  count_x1;
   logic [SUM_W-1:0]  count_x2;
   logic [SUM_W-1:0]  vb_next;
   logic [SUM_W-1:0]  ch_fast;
   logic [DVS_W-1:0]  dvs;
   logic [DATA_W-1:0] acc;
   logic              accept;
   mid_entry_type     data_ent;
   mid_entry_type     tab_ent;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CHANNEL_COUNT_RESET;
         res_en_ff <= 1'b0;
         limit_ff  <= CHANNEL_LIMIT_RESET;
      end else if (valid) begin
         case (csr_index)
            CSR_CHANNEL_COUNT:   count_ff  <= csr_data;
            CSR_RESIDUAL_ENABLE: res_en_ff <= csr_data[0];
            CSR_CHANNEL_LIMIT:   limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign count_eff = (count_ff == '0) ? CFG_W'(1) : count_ff;
   assign count_x1  = {1'b0, count_eff};
   assign count_x2  = {count_eff, 1'b0};
   assign sum       = {1'b0, vbase_ff} + SUM_W'(lane_ff);
   assign vb_next   = {1'b0, vbase_ff} + SUM_W'(LANE_COUNT);
   assign acc       = req_conv_value + (res_en_ff ? req_residual_value : '0);
   assign dvs       = DVS_W'(count_eff) << step_ff;

   always_comb begin
      if (sum < count_x1) begin
         ch_fast = sum;
      end else begin
         ch_fast = sum - count_x1;
      end
   end

   always_comb begin
      data_ent       = '0;
      data_ent.kind  = KIND_DATA;
      data_ent.last  = req_in_last;
      data_ent.value = acc;
      data_ent.idx   = TAB_IDX_W'(ch_fast[CFG_W-1:0]);
      data_ent.zero  = (ch_fast[CFG_W-1:0] >= limit_ff);

      tab_ent       = '0;
      tab_ent.kind  = KIND_TABLE;
      tab_ent.idx   = TAB_IDX_W'(req_table_channel);
      tab_ent.value = req_table_bias;
      tab_ent.mult  = req_table_multiplier;
      tab_ent.shift = req_table_shift;
   end

   always_comb begin
      state_in = state_ff;
      vbase_in = vbase_ff;
      lane_in  = lane_ff;
      hold_in  = hold_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      mq_push  = 1'b0;
      mq_data  = data_ent;
      full     = 1'b1;
      accept   = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            full   = mq_full;
            accept = push && !mq_full;
            if (accept) begin
               if (req_kind == KIND_TABLE) begin
                  mq_push = 1'b1;
                  mq_data = tab_ent;
               end else begin
                  if (req_in_last) begin
                     vbase_in = '0;
                     lane_in  = '0;
                  end else if (lane_ff == LANE_W'(LANE_COUNT - 1)) begin
                     lane_in  = '0;
                     vbase_in = (vb_next >= count_x1) ? '0 : vb_next[CFG_W-1:0];
                  end else begin
                     lane_in = lane_ff + 1'b1;
                  end
                  if (sum < count_x2) begin
                     mq_push = 1'b1;
                  end else begin
                     hold_in  = data_ent;
                     rem_in   = sum;
                     step_in  = STEP_W'(SUM_W - 1);
                     state_in = FE_DIVIDE;
                  end
               end
            end
         end
         FE_DIVIDE: begin
            if (DVS_W'(rem_ff) >= dvs) begin
               rem_in = rem_ff - dvs[SUM_W-1:0];
            end
            if (step_ff == '0) begin
               state_in = FE_PUSH;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         FE_PUSH: begin
            mq_data      = hold_ff;
            mq_data.idx  = TAB_IDX_W'(rem_ff[CFG_W-1:0]);
            mq_data.zero = (rem_ff[CFG_W-1:0] >= limit_ff);
            if (!mq_full) begin
               mq_push  = 1'b1;
               state_in = FE_IDLE;
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         vbase_ff <= '0;
         lane_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vbase_ff <= vbase_in;
         lane_ff  <= lane_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

endmodule

@@ hdl/rqlr_back.sv @@
// Back end: per-channel tables, bias add, multiply, shift, saturate, leaky
// ReLU and the result queue. Depends on rqlr_pkg.
module rqlr_back
   import rqlr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mid_entry_type mq_head,
   input  logic          mq_empty,
   output logic          mq_pop,
   input  logic          pop,
   output logic          empty,
   output logic [OUT_W-1:0] rsp_out_value,
   output logic          rsp_out_last
);

   tab_entry_type tab_mem [MAX_CHANNEL_COUNT];

   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   tab_entry_type              rd1_ff;
   logic [DATA_W-1:0]          acc1_ff;
   logic                       last1_ff, zero1_ff;
   logic signed [DATA_W-1:0]   sum2_ff, mult2_ff;
   logic [SHIFT_W-1:0]         shift2_ff, shift3_ff;
   logic                       last2_ff, zero2_ff, last3_ff, zero3_ff, last4_ff, zero4_ff;
   logic signed [2*DATA_W-1:0] prod3_ff;
   logic signed [DATA_W-1:0]   low4_ff;

   out_entry_type              oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W:0]          oq_wr_ff, oq_rd_ff;
   logic [OQ_PTR_W:0]          oq_used;
   logic [OQ_CNT_W-1:0]        in_use;
   logic                       issue;
   logic                       issue_data;
   logic signed [OUT_W-1:0]    sat;
   logic signed [11:0]         leak;
   out_entry_type              oq_new;

   assign oq_used = oq_wr_ff - oq_rd_ff;
   assign in_use  = OQ_CNT_W'(oq_used) + OQ_CNT_W'(v1_ff) + OQ_CNT_W'(v2_ff)
                  + OQ_CNT_W'(v3_ff) + OQ_CNT_W'(v4_ff);

   assign issue = !mq_empty &&
                  ((mq_head.kind == KIND_TABLE) || (in_use < OQ_CNT_W'(OQ_DEPTH)));
   assign issue_data = issue && (mq_head.kind == KIND_DATA);
   assign mq_pop = issue;

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (issue && (mq_head.kind == KIND_TABLE)) begin
         tab_mem[mq_head.idx] <= '{bias: mq_head.value, mult: mq_head.mult,
                                   shift: mq_head.shift};
      end
      if (issue_data) begin
         rd1_ff <= tab_mem[mq_head.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue_data;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc1_ff   <= mq_head.value;
      last1_ff  <= mq_head.last;
      zero1_ff  <= mq_head.zero;

      sum2_ff   <= acc1_ff + rd1_ff.bias;
      mult2_ff  <= rd1_ff.mult;
      shift2_ff <= rd1_ff.shift;
      last2_ff  <= last1_ff;
      zero2_ff  <= zero1_ff;

      prod3_ff  <= sum2_ff * mult2_ff;
      shift3_ff <= shift2_ff;
      last3_ff  <= last2_ff;
      zero3_ff  <= zero2_ff;

      low4_ff   <= DATA_W'(prod3_ff >>> shift3_ff);
      last4_ff  <= last3_ff;
      zero4_ff  <= zero3_ff;
   end

   // saturate to int8, then leaky slope 13/128 with floor; zero for channels at or above the limit
   always_comb begin
      if (low4_ff > SAT_HI) begin
         sat = SAT_HI[OUT_W-1:0];
      end else if (low4_ff < SAT_LO) begin
         sat = SAT_LO[OUT_W-1:0];
      end else begin
         sat = low4_ff[OUT_W-1:0];
      end
      leak = 12'(sat) * LEAK_MUL;
      oq_new.last = last4_ff;
      if (zero4_ff) begin
         oq_new.value = '0;
      end else if (sat[OUT_W-1]) begin
         oq_new.value = OUT_W'(leak >>> LEAK_SHIFT);
      end else begin
         oq_new.value = sat;
      end
   end

   assign empty         = (oq_wr_ff == oq_rd_ff);
   assign rsp_out_value = oq_ff[oq_rd_ff[OQ_PTR_W-1:0]].value;
   assign rsp_out_last  = oq_ff[oq_rd_ff[OQ_PTR_W-1:0]].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff <= '0;
         oq_rd_ff <= '0;
      end else begin
         if (v4_ff) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (pop && !empty) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v4_ff) begin
         oq_ff[oq_wr_ff[OQ_PTR_W-1:0]] <= oq_new;
      end
   end

endmodule

@@ hdl/requant_leaky_relu_fuse.sv @@
// Requantise, bias and leaky ReLU for int8 convolution output, one element
// per transaction. Top level; depends on rqlr_pkg, rqlr_front,
// rqlr_mid_queue and rqlr_back.
//
// Input side is a queue: a transaction is taken when push is high and full
// is low. kind 0 carries one accumulator element, kind 1 loads bias,
// multiplier and shift for one channel and gives no result. Results are
// read as a queue: out_value/out_last are valid while empty is low and are
// taken by pop. Configuration writes use valid/ready (ready is always high)
// and should be made while the block is idle.
// Throughput is one transaction per cycle while full is low. When the lane
// channel needs a full remainder (base + lane at least twice the channel
// count, e.g. a very small count), the element goes through the shift-subtract
// remainder unit in the front end, one bit a cycle, and the front holds full
// until the element is pushed to the mid queue.
// A stalled reader fills the eight-entry result queue; the back end then
// stops issuing, the mid queue fills and full rises. No result is dropped.
// Reset (synchronous) empties both queues, clears the lane counters and
// loads the register defaults; channel tables are not cleared.
module requant_leaky_relu_fuse
   import rqlr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid,
   output logic                 ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_kind,
   input  logic [DATA_W-1:0]    req_conv_value,
   input  logic [DATA_W-1:0]    req_residual_value,
   input  logic                 req_in_last,
   input  logic [TCH_W-1:0]     req_table_channel,
   input  logic [DATA_W-1:0]    req_table_bias,
   input  logic [DATA_W-1:0]    req_table_multiplier,
   input  logic [SHIFT_W-1:0]   req_table_shift,
   output logic                 empty,
   input  logic                 pop,
   output logic [OUT_W-1:0]     rsp_out_value,
   output logic                 rsp_out_last
);

   logic          mq_push;
   mid_entry_type mq_data;
   logic          mq_full;
   logic          mq_pop;
   mid_entry_type mq_head;
   logic          mq_empty;

   rqlr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .valid                (valid),
      .ready                (ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .push                 (push),
      .full                 (full),
      .req_kind             (req_kind),
      .req_conv_value       (req_conv_value),
      .req_residual_value   (req_residual_value),
      .req_in_last          (req_in_last),
      .req_table_channel    (req_table_channel),
      .req_table_bias       (req_table_bias),
      .req_table_multiplier (req_table_multiplier),
      .req_table_shift      (req_table_shift),
      .mq_push              (mq_push),
      .mq_data              (mq_data),
      .mq_full              (mq_full)
   );

   rqlr_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (mq_push),
      .push_data (mq_data),
      .q_full    (mq_full),
      .pop_en    (mq_pop),
      .head      (mq_head),
      .q_empty   (mq_empty)
   );

   rqlr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .mq_head       (mq_head),
      .mq_empty      (mq_empty),
      .mq_pop        (mq_pop),
      .pop           (pop),
      .empty         (empty),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

@@ dv/requant_leaky_relu_fuse_tb.sv @@
// Self-checking testbench for requant_leaky_relu_fuse: random stimulus on the push/full
// request queue, random pops on the result queue, and a scoreboard that predicts every result.
// Depends on rqlr_pkg and the requant_leaky_relu_fuse RTL.
module requant_leaky_relu_fuse_tb
   import rqlr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS  = 168;
   localparam int PHASES       = 11;

   typedef struct packed {
      logic                kind;
      logic [DATA_W-1:0]   conv;
      logic [DATA_W-1:0]   resid;
      logic                last;
      logic [TCH_W-1:0]    tch;
      logic [DATA_W-1:0]   tbias;
      logic [DATA_W-1:0]   tmult;
      logic [SHIFT_W-1:0]  tshift;
   } rqlr_req_type;

   class rqlr_scoreboard;
      logic [CFG_W-1:0]   chan_count;
      logic               res_en;
      logic [CFG_W-1:0]   chan_limit;
      logic [CFG_W-1:0]   vec_base;
      logic [LANE_W-1:0]  lane_pos;
      logic [DATA_W-1:0]  bias_tab [MAX_CHANNEL_COUNT];
      logic [DATA_W-1:0]  mult_tab [MAX_CHANNEL_COUNT];
      logic [SHIFT_W-1:0] shift_tab[MAX_CHANNEL_COUNT];
      bit                 written  [MAX_CHANNEL_COUNT];
      out_entry_type      expected_q[$];
      int                 errors;

      function new();
         chan_count = CHANNEL_COUNT_RESET;
         res_en     = 1'b0;
         chan_limit = CHANNEL_LIMIT_RESET;
         vec_base   = '0;
         lane_pos   = '0;
         errors     = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_CHANNEL_COUNT:   chan_count = data;
            CSR_RESIDUAL_ENABLE: res_en     = data[0];
            CSR_CHANNEL_LIMIT:   chan_limit = data;
            default: ;
         endcase
      endfunction

      function int unsigned eff_count();
         return (chan_count == 0) ? 1 : chan_count;
      endfunction

      function int unsigned next_channel();
         return (vec_base + lane_pos) % eff_count();
      endfunction

      function logic [OUT_W-1:0] requantise(rqlr_req_type r, int unsigned ch);
         logic [DATA_W-1:0] acc;
         longint            prod;
         longint            shifted;
         int                v;
         acc = r.conv;
         if (res_en) acc = acc + r.resid;
         acc = acc + bias_tab[ch];
         prod    = longint'($signed(acc)) * longint'($signed(mult_tab[ch]));
         shifted = prod >>> shift_tab[ch];
         v       = $signed(shifted[31:0]);
         if (v > 127) v = 127;
         else if (v < -128) v = -128;
         if (v < 0) v = (v * 13) >>> 7;
         if (ch >= chan_limit) v = 0;
         return v[OUT_W-1:0];
      endfunction

      function void note_request(rqlr_req_type r);
         int unsigned   ch;
         out_entry_type e;
         if (r.kind == KIND_TABLE) begin
            bias_tab[r.tch]  = r.tbias;
            mult_tab[r.tch]  = r.tmult;
            shift_tab[r.tch] = r.tshift;
            written[r.tch]   = 1'b1;
            return;
         end
         ch      = next_channel();
         e.value = requantise(r, ch);
         e.last  = r.last;
         expected_q.push_back(e);
         if (r.last) begin
            vec_base = '0;
            lane_pos = '0;
         end else if (lane_pos == LANE_COUNT - 1) begin
            lane_pos = '0;
            vec_base = CFG_W'(vec_base + LANE_COUNT);
            if (vec_base >= eff_count()) vec_base = '0;
         end else begin
            lane_pos = lane_pos + 1'b1;
         end
      endfunction

      function void check_result(logic [OUT_W-1:0] value, logic last);
         out_entry_type e;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: out_value %0d out_last %0b",
                   $signed(value), last);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (value !== e.value) begin
            $error("out_value: expected %0d, actual %0d", $signed(e.value), $signed(value));
            errors++;
         end
         if (last !== e.last) begin
            $error("out_last: expected %0b, actual %0b", e.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   logic                 push;
   logic                 full;
   logic                 req_kind;
   logic [DATA_W-1:0]    req_conv_value;
   logic [DATA_W-1:0]    req_residual_value;
   logic                 req_in_last;
   logic [TCH_W-1:0]     req_table_channel;
   logic [DATA_W-1:0]    req_table_bias;
   logic [DATA_W-1:0]    req_table_multiplier;
   logic [SHIFT_W-1:0]   req_table_shift;
   logic                 empty;
   logic                 pop;
   logic [OUT_W-1:0]     rsp_out_value;
   logic                 rsp_out_last;

   rqlr_scoreboard sb;
   bit             tx_burst;
   bit             rx_burst;
   int unsigned    cycle_count;

   requant_leaky_relu_fuse i_dut (
      .clock                (clock),
      .reset                (reset),
      .valid                (valid),
      .ready                (ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .push                 (push),
      .full                 (full),
      .req_kind             (req_kind),
      .req_conv_value       (req_conv_value),
      .req_residual_value   (req_residual_value),
      .req_in_last          (req_in_last),
      .req_table_channel    (req_table_channel),
      .req_table_bias       (req_table_bias),
      .req_table_multiplier (req_table_multiplier),
      .req_table_shift      (req_table_shift),
      .empty                (empty),
      .pop                  (pop),
      .rsp_out_value        (rsp_out_value),
      .rsp_out_last         (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rqlr_req_type data_req(logic [DATA_W-1:0] conv,
                                             logic [DATA_W-1:0] resid, logic last);
      rqlr_req_type r;
      r        = '0;
      r.kind   = KIND_DATA;
      r.conv   = conv;
      r.resid  = resid;
      r.last   = last;
      r.tch    = TCH_W'($urandom);
      r.tbias  = $urandom;
      r.tmult  = $urandom;
      r.tshift = SHIFT_W'($urandom);
      return r;
   endfunction

   function automatic rqlr_req_type table_req(int unsigned ch, logic [DATA_W-1:0] bias,
                                              logic [DATA_W-1:0] mult,
                                              logic [SHIFT_W-1:0] sh);
      rqlr_req_type r;
      r        = '0;
      r.kind   = KIND_TABLE;
      r.conv   = $urandom;
      r.resid  = $urandom;
      r.last   = 1'($urandom_range(0, 1));
      r.tch    = TCH_W'(ch);
      r.tbias  = bias;
      r.tmult  = mult;
      r.tshift = sh;
      return r;
   endfunction

   // mostly plausible scales so outputs spread over the int8 range
   function automatic rqlr_req_type random_table_req(int unsigned ch);
      logic [DATA_W-1:0] mult;
      if ($urandom_range(0, 99) < 30)
         return table_req(ch, $urandom, $urandom, SHIFT_W'($urandom));
      mult = $urandom_range(1 << 20, 1 << 30);
      if ($urandom_range(0, 3) == 0) mult = -mult;
      return table_req(ch, $urandom_range(0, 2000) - 1000, mult,
                       SHIFT_W'($urandom_range(20, 40)));
   endfunction

   function automatic logic [DATA_W-1:0] random_element();
      if ($urandom_range(0, 99) < 60) return $urandom_range(0, 1 << 16) - (1 << 15);
      return $urandom;
   endfunction

   task automatic send_req(rqlr_req_type r);
      int gap;
      gap = pick_gap(tx_burst);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push                 <= 1'b1;
      req_kind             <= r.kind;
      req_conv_value       <= r.conv;
      req_residual_value   <= r.resid;
      req_in_last          <= r.last;
      req_table_channel    <= r.tch;
      req_table_bias       <= r.tbias;
      req_table_multiplier <= r.tmult;
      req_table_shift      <= r.tshift;
      do @(posedge clock); while (full);
      sb.note_request(r);
      @(negedge clock);
   endtask

   // data element; loads the table entry first if its channel has never been written
   task automatic send_element(logic [DATA_W-1:0] conv, logic [DATA_W-1:0] resid, logic last);
      int unsigned ch;
      ch = sb.next_channel();
      if (!sb.written[ch]) send_req(random_table_req(ch));
      send_req(data_req(conv, resid, last));
   endtask

   task automatic drain_results();
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // leaves valid high; the caller drops it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!ready);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   initial begin
      pop = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         int gap;
         gap = pick_gap(rx_burst);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         sb.check_result(rsp_out_value, rsp_out_last);
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int unsigned ph_count[PHASES];
      bit          ph_res  [PHASES];
      int unsigned ph_limit[PHASES];
      ph_count             = '{16, 512, 3, 512, 0, 1, 100, 40, 0, 0, 0};
      ph_res               = '{1, 0, 1, 1, 1, 0, 1, 0, 0, 0, 0};
      ph_limit             = '{512, 512, 2, 0, 1, 1, 50, 512, 0, 0, 0};
      sb                   = new();
      tx_burst             = 1'b0;
      rx_burst             = 1'b0;
      reset                = 1'b1;
      valid                = 1'b0;
      csr_index            = '0;
      csr_data             = '0;
      push                 = 1'b0;
      req_kind             = KIND_DATA;
      req_conv_value       = '0;
      req_residual_value   = '0;
      req_in_last          = 1'b0;
      req_table_channel    = '0;
      req_table_bias       = '0;
      req_table_multiplier = '0;
      req_table_shift      = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, so every element maps to channel 0
      send_req(table_req(0, 32'd0, 32'd1, 6'd0));
      send_req(data_req(32'd0, 32'hFFFF_FFFF, 1'b0));
      send_req(data_req(32'd127, 32'd0, 1'b0));
      send_req(data_req(32'd128, 32'd5, 1'b0));
      send_req(data_req(-32'sd128, 32'h7FFF_FFFF, 1'b0));
      send_req(data_req(-32'sd129, 32'h8000_0000, 1'b0));
      send_req(data_req(32'hFFFF_FFFF, 32'd0, 1'b0));
      send_req(data_req(32'h7FFF_FFFF, 32'd0, 1'b0));
      send_req(data_req(32'h8000_0000, 32'd0, 1'b1));
      send_req(table_req(0, 32'h7FFF_FFFF, 32'h8000_0000, 6'd63));
      send_req(data_req(32'd1, 32'd0, 1'b0));
      send_req(data_req(32'h8000_0000, 32'd0, 1'b0));
      send_req(table_req(0, -32'sd5, 32'h7FFF_FFFF, 6'd31));
      send_req(data_req(32'd100, 32'd0, 1'b0));
      send_req(data_req(-32'sd100, 32'd0, 1'b1));
      send_req(table_req(511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1));
      send_req(table_req(0, 32'd0, 32'h0000_0100, 6'd9));
      send_req(data_req(-32'sd1000, 32'd0, 1'b0));
      send_req(data_req(32'd1000, 32'd0, 1'b1));

      for (int p = 0; p < PHASES; p++) begin
         if (p >= 8) begin
            ph_count[p] = $urandom_range(1, 512);
            ph_res[p]   = 1'($urandom_range(0, 1));
            ph_limit[p] = $urandom_range(0, 512);
         end
         drain_results();
         write_csr(CSR_CHANNEL_COUNT, CFG_W'(ph_count[p]));
         write_csr(CSR_RESIDUAL_ENABLE, CFG_W'(ph_res[p]));
         write_csr(CSR_CHANNEL_LIMIT, CFG_W'(ph_limit[p]));
         valid <= 1'b0;
         tx_burst = (p % 4 == 1);
         rx_burst = (p % 4 == 1) || (p % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
            if ($urandom_range(0, 99) < 10)
               send_req(random_table_req($urandom_range(0, MAX_CHANNEL_COUNT - 1)));
            else
               send_element(random_element(), random_element(), $urandom_range(0, 99) < 3);
         end
      end

      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/rqlr_pkg.sv
hdl/rqlr_mid_queue.sv
hdl/rqlr_front.sv
hdl/rqlr_back.sv
hdl/requant_leaky_relu_fuse.sv
dv/requant_leaky_relu_fuse_tb.sv
